>>> hw/rtl/hcd_pkg.sv
package hcd_pkg;

   localparam int BYTE_WIDTH     = 8;
   localparam int SIZE_WIDTH     = 24;
   localparam int MAX_BODY_BYTES = 65536;
   localparam int COUNT_WIDTH    = $clog2(MAX_BODY_BYTES + 1);
   localparam int LENGTH_WIDTH   = 17;

   localparam logic [BYTE_WIDTH-1:0] CHAR_TAB    = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF     = 8'h0a;
   localparam logic [BYTE_WIDTH-1:0] CHAR_VT     = 8'h0b;
   localparam logic [BYTE_WIDTH-1:0] CHAR_FF     = 8'h0c;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CR     = 8'h0d;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS   = 8'h2b;
   localparam logic [BYTE_WIDTH-1:0] CHAR_MINUS  = 8'h2d;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE   = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_X = 8'h78;

   localparam logic [1:0] PREFIX_NONE      = 2'd0;
   localparam logic [1:0] PREFIX_ZERO      = 2'd1;
   localparam logic [1:0] PREFIX_HEX_MARK  = 2'd2;
   localparam logic [1:0] PREFIX_DIGITS    = 2'd3;

   localparam logic [1:0] TRAILER_BYTES = 2'd2;

   typedef enum logic [6:0] {
      PH_LEAD    = 7'b0000001,
      PH_SIGNED  = 7'b0000010,
      PH_DIGITS  = 7'b0000100,
      PH_IGNORE  = 7'b0001000,
      PH_DATA    = 7'b0010000,
      PH_TRAILER = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

endpackage

>>> hw/rtl/hcd_stream_if.sv
interface hcd_req_if;
   logic                              valid;
   logic                              ready;
   logic [hcd_pkg::BYTE_WIDTH-1:0]    in_byte;
   logic                              last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface hcd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hcd_pkg::BYTE_WIDTH-1:0]    data_byte;
   logic                              data_valid;
   logic                              end_of_stream;
   logic [hcd_pkg::LENGTH_WIDTH-1:0]  decoded_length;

   modport source (output valid, output data_byte, output data_valid,
                   output end_of_stream, output decoded_length, input ready);
   modport sink   (input valid, input data_byte, input data_valid,
                   input end_of_stream, input decoded_length, output ready);
endinterface

>>> hw/rtl/http_chunked_decoder.sv
// Chunked HTTP body decoder. Takes one raw body byte per request and, when that
// byte is payload within the body limit or carries last_byte, returns one
// response; bytes of size lines, chunk trailers and anything after the
// terminating chunk give no response unless marked last. A request is taken
// every cycle the response register is empty or being drained, so one byte per
// clock is sustained, each response shown in the cycle after its request; the
// only limit is the one-entry response register. Size lines are parsed as hex
// with optional leading whitespace, sign and 0x prefix, saturating at the size
// width; a size of zero or less, or an empty line, ends decoding. The last byte
// reports the total payload count and returns the block to its reset state.
module http_chunked_decoder (
   input  logic        clock,
   input  logic        reset,
   hcd_req_if.sink     req_chan,
   hcd_rsp_if.source   rsp_chan
);

   localparam int SW = hcd_pkg::SIZE_WIDTH;
   localparam int CW = hcd_pkg::COUNT_WIDTH;
   localparam int BW = hcd_pkg::BYTE_WIDTH;

   function automatic logic is_hex(input logic [BW-1:0] b);
      return (b >= hcd_pkg::CHAR_ZERO && b <= hcd_pkg::CHAR_NINE) ||
             (b >= hcd_pkg::CHAR_LOWER_A && b <= hcd_pkg::CHAR_LOWER_F) ||
             (b >= hcd_pkg::CHAR_UPPER_A && b <= hcd_pkg::CHAR_UPPER_F);
   endfunction

   function automatic logic [3:0] hex_val(input logic [BW-1:0] b);
      logic [BW-1:0] d;
      d = '0;
      if (b >= hcd_pkg::CHAR_ZERO && b <= hcd_pkg::CHAR_NINE) begin
         d = b - hcd_pkg::CHAR_ZERO;
      end else if (b >= hcd_pkg::CHAR_LOWER_A && b <= hcd_pkg::CHAR_LOWER_F) begin
         d = b - hcd_pkg::CHAR_LOWER_A + BW'(10);
      end else if (b >= hcd_pkg::CHAR_UPPER_A && b <= hcd_pkg::CHAR_UPPER_F) begin
         d = b - hcd_pkg::CHAR_UPPER_A + BW'(10);
      end
      return d[3:0];
   endfunction

   function automatic logic is_space(input logic [BW-1:0] b);
      return b == hcd_pkg::CHAR_SPACE || b == hcd_pkg::CHAR_TAB ||
             b == hcd_pkg::CHAR_LF || b == hcd_pkg::CHAR_VT ||
             b == hcd_pkg::CHAR_FF || b == hcd_pkg::CHAR_CR;
   endfunction

   hcd_pkg::phase_type phase_ff, phase_in;
   logic [SW-1:0]  acc_ff, acc_in;
   logic           neg_ff, neg_in;
   logic [1:0]     prefix_ff, prefix_in;
   logic           cr_ff, cr_in;
   logic [SW-1:0]  data_left_ff, data_left_in;
   logic [1:0]     trailer_left_ff, trailer_left_in;
   logic [CW-1:0]  emitted_ff, emitted_in;

   logic                           rsp_valid_ff;
   logic [BW-1:0]                  data_byte_ff;
   logic                           data_valid_ff;
   logic                           eos_ff;
   logic [hcd_pkg::LENGTH_WIDTH-1:0] length_ff;

   logic          req_acc;
   logic [BW-1:0] b;
   logic          last;
   logic          hit;
   logic [3:0]    h;
   logic          valid;
   logic          line_end;
   logic [SW-1:0] size;
   logic [SW-1:0] left_dec;

   assign req_acc        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign b              = req_chan.in_byte;
   assign last           = req_chan.last_byte;
   assign hit            = is_hex(b);
   assign h              = hex_val(b);
   assign line_end       = (b == hcd_pkg::CHAR_LF) && cr_ff;
   assign size           = neg_ff ? '0 : acc_ff;
   assign left_dec       = data_left_ff - SW'(1);

   always_comb begin
      phase_in        = phase_ff;
      acc_in          = acc_ff;
      neg_in          = neg_ff;
      prefix_in       = prefix_ff;
      cr_in           = cr_ff;
      data_left_in    = data_left_ff;
      trailer_left_in = trailer_left_ff;
      emitted_in      = emitted_ff;
      valid           = 1'b0;

      case (phase_ff)
         hcd_pkg::PH_LEAD,
         hcd_pkg::PH_SIGNED,
         hcd_pkg::PH_DIGITS,
         hcd_pkg::PH_IGNORE: begin
            if (line_end) begin
               acc_in    = '0;
               neg_in    = 1'b0;
               prefix_in = hcd_pkg::PREFIX_NONE;
               cr_in     = 1'b0;
               if (size == '0) begin
                  phase_in = hcd_pkg::PH_DONE;
               end else begin
                  data_left_in = size;
                  phase_in     = hcd_pkg::PH_DATA;
               end
            end else if (phase_ff == hcd_pkg::PH_LEAD && is_space(b)) begin
               cr_in = (b == hcd_pkg::CHAR_CR);
            end else if (phase_ff == hcd_pkg::PH_LEAD &&
                         (b == hcd_pkg::CHAR_PLUS || b == hcd_pkg::CHAR_MINUS)) begin
               neg_in   = (b == hcd_pkg::CHAR_MINUS);
               cr_in    = 1'b0;
               phase_in = hcd_pkg::PH_SIGNED;
            end else begin
               cr_in = (phase_ff != hcd_pkg::PH_LEAD) && (b == hcd_pkg::CHAR_CR);
               if (phase_ff == hcd_pkg::PH_DIGITS) begin
                  if (hit) begin
                     if (acc_ff[SW-1 -: 4] != 4'd0) begin
                        acc_in = '1;
                     end else begin
                        acc_in = {acc_ff[SW-5:0], h};
                     end
                     prefix_in = hcd_pkg::PREFIX_DIGITS;
                  end else if ((b == hcd_pkg::CHAR_LOWER_X || b == hcd_pkg::CHAR_UPPER_X) &&
                               prefix_ff == hcd_pkg::PREFIX_ZERO) begin
                     prefix_in = hcd_pkg::PREFIX_HEX_MARK;
                  end else begin
                     phase_in = hcd_pkg::PH_IGNORE;
                  end
               end else if (phase_ff != hcd_pkg::PH_IGNORE) begin
                  if (hit) begin
                     acc_in    = SW'(h);
                     prefix_in = (h == 4'd0) ? hcd_pkg::PREFIX_ZERO
                                             : hcd_pkg::PREFIX_DIGITS;
                     phase_in  = hcd_pkg::PH_DIGITS;
                  end else begin
                     phase_in = hcd_pkg::PH_IGNORE;
                  end
               end
            end
         end
         hcd_pkg::PH_DATA: begin
            if (emitted_ff < CW'(hcd_pkg::MAX_BODY_BYTES)) begin
               valid      = 1'b1;
               emitted_in = emitted_ff + CW'(1);
            end
            if (data_left_ff != '0) begin
               data_left_in = left_dec;
            end
            if (data_left_ff == '0 || left_dec == '0) begin
               trailer_left_in = hcd_pkg::TRAILER_BYTES;
               phase_in        = hcd_pkg::PH_TRAILER;
            end
         end
         hcd_pkg::PH_TRAILER: begin
            if (trailer_left_ff != 2'd0) begin
               trailer_left_in = trailer_left_ff - 2'd1;
            end
            if (trailer_left_ff <= 2'd1) begin
               acc_in    = '0;
               neg_in    = 1'b0;
               prefix_in = hcd_pkg::PREFIX_NONE;
               cr_in     = 1'b0;
               phase_in  = hcd_pkg::PH_LEAD;
            end
         end
         default: begin
            phase_in = hcd_pkg::PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= hcd_pkg::PH_LEAD;
         acc_ff          <= '0;
         neg_ff          <= 1'b0;
         prefix_ff       <= hcd_pkg::PREFIX_NONE;
         cr_ff           <= 1'b0;
         data_left_ff    <= '0;
         trailer_left_ff <= 2'd0;
         emitted_ff      <= '0;
      end else if (req_acc) begin
         if (last) begin
            phase_ff        <= hcd_pkg::PH_LEAD;
            acc_ff          <= '0;
            neg_ff          <= 1'b0;
            prefix_ff       <= hcd_pkg::PREFIX_NONE;
            cr_ff           <= 1'b0;
            data_left_ff    <= '0;
            trailer_left_ff <= 2'd0;
            emitted_ff      <= '0;
         end else begin
            phase_ff        <= phase_in;
            acc_ff          <= acc_in;
            neg_ff          <= neg_in;
            prefix_ff       <= prefix_in;
            cr_ff           <= cr_in;
            data_left_ff    <= data_left_in;
            trailer_left_ff <= trailer_left_in;
            emitted_ff      <= emitted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= valid || last;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         data_byte_ff  <= valid ? b : '0;
         data_valid_ff <= valid;
         eos_ff        <= last;
         length_ff     <= last ? hcd_pkg::LENGTH_WIDTH'(emitted_in) : '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.data_byte      = data_byte_ff;
   assign rsp_chan.data_valid     = data_valid_ff;
   assign rsp_chan.end_of_stream  = eos_ff;
   assign rsp_chan.decoded_length = length_ff;

`ifndef SYNTHESIS
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (req_acc && last) |=> (phase_ff == hcd_pkg::PH_LEAD && emitted_ff == '0))
      else $error("state not cleared after last byte");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.data_valid) |-> rsp_chan.end_of_stream)
      else $error("response without payload or end of stream");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hcd_pkg::PH_DATA) |-> (data_left_ff != '0))
      else $error("data phase with no bytes left");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= CW'(hcd_pkg::MAX_BODY_BYTES))
      else $error("emitted count beyond body limit");

   a_take_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while response stalled");
`endif

endmodule
